// ===== sv/island_union_find_macros.svh =====
// Assertion macros shared by the island union-find RTL.
// Defining ASSERT_OFF compiles every assertion away.
`ifndef ISLAND_UNION_FIND_MACROS_SVH
`define ISLAND_UNION_FIND_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property checked at each rising clock edge outside reset.
`define IUF_ASSERT(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("island_union_find assertion failed");
// Implication from an antecedent to a consequent in the following cycle.
`define IUF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("island_union_find assertion failed");
`else
`define IUF_ASSERT(name, clk, rstn, prop)
`define IUF_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/iuf_pkg.sv =====
// Package for the island union-find block: sizes, operation codes,
// transaction structs and controller/datapath command structs. No dependencies.
package iuf_pkg;
	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int COUNT_W = IDX_W + 1;
	localparam int STEP_W = COUNT_W;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_ELEMENTS);
	localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_ELEMENTS);
	localparam logic [APB_ADDR_W-1:0] REG_ELEMENT_COUNT = '0;

	typedef enum logic [1:0] {
		FUNC_INIT    = 2'd0,
		FUNC_MERGE   = 2'd1,
		FUNC_LINK    = 2'd2,
		FUNC_RESOLVE = 2'd3
	} func_t;

	typedef struct packed {
		func_t            func;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
		logic             is_active;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] root_index;
		logic             own_static;
		logic             already_same;
		logic             error;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic start_a;
		logic start_b;
		logic step;
		logic save_r1;
		logic finish;
	} iuf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic  err;
		logic  found;
		func_t func;
	} iuf_status_t;
endpackage

// ===== sv/iuf_dpath.sv =====
// Datapath of the island union-find block: item registers, parent and flag
// memories, the root walk pointer and the result register. Uses iuf_pkg.
module iuf_dpath import iuf_pkg::*; (
	input  logic               clk,
	input  iuf_cmd_t           cmd,
	output iuf_status_t        status,
	input  in_item_t           in_data,
	input  logic [COUNT_W-1:0] element_count,
	output out_item_t          out_data
);
	logic [IDX_W-1:0] parent_mem [MAX_ELEMENTS];
	logic             flag_mem [MAX_ELEMENTS];

	in_item_t         item_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] r1_q;
	logic [STEP_W-1:0] steps_q;
	logic [IDX_W-1:0] par_rd_q;
	logic             flag_rd_q;
	out_item_t        res_q;

	logic [IDX_W-1:0] par_raddr;
	logic             pw_en;
	logic [IDX_W-1:0] pw_addr;
	logic [IDX_W-1:0] pw_data;
	logic             fw_en;
	logic [IDX_W-1:0] fw_addr;
	logic             fw_data;
	logic             a_ok;
	logic             b_ok;
	logic             err_w;
	logic             same_w;
	out_item_t        res_d;

	// Range check of the held indices against the configured count.
	assign a_ok = {1'b0, item_q.first_index} < element_count;
	assign b_ok = {1'b0, item_q.second_index} < element_count;
	assign err_w = !a_ok || ((item_q.func == FUNC_MERGE) && !b_ok);
	assign same_w = (r1_q == cur_q);

	assign status.err = err_w;
	assign status.found = (par_rd_q == cur_q) || (steps_q == STEP_LIMIT);
	assign status.func = item_q.func;

	// Parent read address follows the walk: start point, next link or hold.
	always_comb begin
		if (cmd.start_a) begin
			par_raddr = item_q.first_index;
		end else if (cmd.start_b) begin
			par_raddr = item_q.second_index;
		end else if (cmd.step) begin
			par_raddr = par_rd_q;
		end else begin
			par_raddr = cur_q;
		end
	end

	// Table updates and the result, committed when the item finishes.
	always_comb begin
		pw_en = 1'b0;
		pw_addr = item_q.first_index;
		pw_data = cur_q;
		fw_en = 1'b0;
		fw_addr = item_q.first_index;
		fw_data = 1'b1;
		res_d = '0;
		if (err_w) begin
			res_d.error = 1'b1;
		end else begin
			case (item_q.func)
				FUNC_INIT: begin
					pw_en = cmd.finish;
					pw_data = item_q.first_index;
					fw_en = cmd.finish;
					fw_data = !item_q.is_active;
					res_d.own_static = !item_q.is_active;
				end
				FUNC_MERGE: begin
					pw_en = cmd.finish && !same_w;
					pw_addr = r1_q;
					res_d.root_index = r1_q;
					res_d.own_static = flag_rd_q;
					res_d.already_same = same_w;
				end
				FUNC_LINK: begin
					fw_en = cmd.finish;
					fw_addr = cur_q;
					res_d.root_index = cur_q;
					res_d.own_static = (cur_q == item_q.first_index) || flag_rd_q;
				end
				default: begin
					pw_en = cmd.finish;
					res_d.root_index = cur_q;
					res_d.own_static = flag_rd_q;
				end
			endcase
		end
	end

	// Memories: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (pw_en) begin
			parent_mem[pw_addr] <= pw_data;
		end
		par_rd_q <= parent_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (fw_en) begin
			flag_mem[fw_addr] <= fw_data;
		end
		flag_rd_q <= flag_mem[item_q.first_index];
	end

	// Item, walk and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
		if (cmd.start_a || cmd.start_b) begin
			cur_q <= par_raddr;
			steps_q <= '0;
		end else if (cmd.step) begin
			cur_q <= par_rd_q;
			steps_q <= steps_q + STEP_W'(1);
		end
		if (cmd.save_r1) begin
			r1_q <= cur_q;
		end
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign out_data = res_q;
endmodule

// ===== sv/iuf_ctrl.sv =====
// Controller of the island union-find block: sequences check, root walks
// and commit, and owns both handshakes. Uses iuf_pkg and the macro header.
`include "island_union_find_macros.svh"
module iuf_ctrl import iuf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  iuf_status_t status,
	output iuf_cmd_t    cmd
);
	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_FIND_A,
		S_FIND_B
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   res_free;

	// The result register can take a new value once the old one is gone.
	assign res_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode and next state.
	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.err || (status.func == FUNC_INIT)) begin
					if (res_free) begin
						cmd.finish = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					cmd.start_a = 1'b1;
					state_d = S_FIND_A;
				end
			end
			S_FIND_A: begin
				if (!status.found) begin
					cmd.step = 1'b1;
				end else if (status.func == FUNC_MERGE) begin
					cmd.save_r1 = 1'b1;
					cmd.start_b = 1'b1;
					state_d = S_FIND_B;
				end else if (res_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FIND_B: begin
				if (!status.found) begin
					cmd.step = 1'b1;
				end else if (res_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= cmd.finish || (out_valid_q && out_stall);
		end
	end

	`IUF_ASSERT(a_finish_free, clk, arst_n, !cmd.finish || res_free)
	`IUF_ASSERT(a_step_not_found, clk, arst_n, !cmd.step || !status.found)
	`IUF_ASSERT_NEXT(a_accept_check, clk, arst_n, in_valid && !in_stall, state_q == S_CHECK)
	`IUF_ASSERT_NEXT(a_finish_shows, clk, arst_n, cmd.finish, out_valid_q)
endmodule

// ===== sv/island_union_find.sv =====
// Island union-find block: disjoint-set table of parent links and static flags.
// Top level holding the configuration register; uses iuf_pkg, iuf_ctrl, iuf_dpath.
//
// Use: an item on in_data (func, first_index, second_index, is_active) is taken
// at a rising edge with in_valid high and in_stall low. Each item gives exactly
// one result on out_data, offered with out_valid and taken when out_stall is low.
// Init writes an entry as its own root; merge, link and resolve walk parent
// links from the addressed entry, one parent memory read per cycle.
// After an item is taken, a check state tests its indices; init or an index
// error commits from there, link and resolve walk from first_index to its root
// and commit, and merge walks from first_index and then second_index. One item
// is worked on at a time; the next is taken the cycle after the previous one
// finishes, while its result may still wait in the output register.
// When the receiver stalls, the result holds and the next item waits at its
// commit until the register is free. Reset clears the control and sets
// element_count to 1024; the tables are not cleared, so every entry must be
// initialised before it is read. The user writes element_count over the APB port
// at byte address 0 only while the block is idle; the block does not enforce it.
module island_union_find import iuf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	logic [COUNT_W-1:0] count_q;
	iuf_cmd_t           cmd;
	iuf_status_t        status;

	// Configuration register write and read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && (paddr == REG_ELEMENT_COUNT)) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_ELEMENT_COUNT) ?
		{{(APB_DATA_W-COUNT_W){1'b0}}, count_q} : '0;

	iuf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	iuf_dpath u_dpath (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.in_data       (in_data),
		.element_count (count_q),
		.out_data      (out_data)
	);
endmodule
